/* hdl/sorted_key_table_unit_assert.svh */
// assertion macros for the sorted key table unit
`ifndef SORTED_KEY_TABLE_UNIT_ASSERT_SVH
`define SORTED_KEY_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTH
// condition that must hold at every clock edge out of reset
`define SKT_ASSERT_HOLD(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sorted key table check failed");
// condition that must hold in the cycle after a trigger
`define SKT_ASSERT_NEXT(label, clk, rst, trig, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error("sorted key table sequence check failed");
`else
`define SKT_ASSERT_HOLD(label, clk, rst, prop)
`define SKT_ASSERT_NEXT(label, clk, rst, trig, prop)
`endif
`endif

/* hdl/skt_pkg.sv */
// shared constants, types and key ordering for the sorted key table
package skt_pkg;

   localparam int DEPTH            = 64;
   localparam int KEY_BITS         = 32;
   localparam int IDX_BITS         = $clog2(DEPTH);
   localparam int CNT_BITS         = $clog2(DEPTH + 1);
   localparam int ACTION_BITS      = 2;
   localparam int STATUS_BITS      = 2;
   localparam int KEY_FIELD_BITS   = 32;
   localparam int POS_FIELD_BITS   = 6;
   localparam int COUNT_FIELD_BITS = 7;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_INSERT = 2'd0,
      ACT_SEARCH = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_DUP     = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_COMMIT
   } state_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic    capture;
      logic    shift_up;
      logic    shift_down;
      logic    compare_signed;
      key_type probe_key;
      key_type new_key;
      cnt_type count;
   } cell_ctrl_type;

   // compare result held by each cell
   typedef struct packed {
      logic lt;
      logic eq;
   } cell_flag_type;

   // map a key to an unsigned value that orders as the selected comparison
   function automatic key_type order_key(key_type k, logic is_signed);
      key_type sign_bit;
      sign_bit = key_type'(is_signed) << (KEY_BITS - 1);
      return k ^ sign_bit;
   endfunction

endpackage

/* hdl/skt_cell.sv */
// one slot of the key chain: holds a key, compares it, shifts with its neighbors
module skt_cell (
   input  logic                    clock,
   input  skt_pkg::cell_ctrl_type  ctrl,
   input  skt_pkg::idx_type        cell_index,
   input  skt_pkg::key_type        left_key,
   input  skt_pkg::key_type        right_key,
   input  logic                    prefix_lt,
   output skt_pkg::key_type        key_out,
   output skt_pkg::cell_flag_type  flag_out
);
   import skt_pkg::*;

   key_type key_ff, key_in;
   logic    lt_ff, lt_in;
   logic    eq_ff, eq_in;
   logic    occupied;
   logic    boundary;

   // compare the probe key against the held key
   always_comb begin
      occupied = cnt_type'(cell_index) < ctrl.count;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (ctrl.capture) begin
         lt_in = occupied && (order_key(key_ff, ctrl.compare_signed) <
                              order_key(ctrl.probe_key, ctrl.compare_signed));
         eq_in = occupied && (key_ff == ctrl.probe_key);
      end
   end

   // this cell is the first one not below the probe key
   assign boundary = prefix_lt & ~lt_ff;

   // shift up on insert, shift down on delete
   always_comb begin
      key_in = key_ff;
      if (ctrl.shift_up) begin
         if (boundary) begin
            key_in = ctrl.new_key;
         end else if (!prefix_lt) begin
            key_in = left_key;
         end
      end else if (ctrl.shift_down) begin
         if (!(prefix_lt && lt_ff)) begin
            key_in = right_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key_out     = key_ff;
   assign flag_out.lt = lt_ff;
   assign flag_out.eq = eq_ff;

endmodule

/* hdl/sorted_key_table_unit.sv */
// top level of the sorted key table: request sequencer over a chain of key cells
//
//  channel   direction  handshake              payload
//  req_      in         req_valid/req_stall    req_action, req_key
//  rsp_      out        rsp_valid/rsp_stall    rsp_status, rsp_position, rsp_entry_count
//  csr_      in         csr_wr_en              csr_wr_data (compare_signed)
//
// each request is handled in steps: on accept the per-cell compare flags are latched,
// then the commit state resolves the slot across the chain and shifts the cells
// reset is synchronous; it clears the state, count, compare mode and response valid, not the key cells
// a stalled result holds the sequencer in its commit state until the transfer completes
// a new request is taken while the previous result still waits in the output register
`include "sorted_key_table_unit_assert.svh"

module sorted_key_table_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [skt_pkg::ACTION_BITS-1:0]        req_action,
   input  logic [skt_pkg::KEY_FIELD_BITS-1:0]     req_key,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [skt_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [skt_pkg::POS_FIELD_BITS-1:0]     rsp_position,
   output logic [skt_pkg::COUNT_FIELD_BITS-1:0]   rsp_entry_count,
   input  logic                                   csr_wr_en,
   input  logic                                   csr_wr_data
);
   import skt_pkg::*;

   state_type     state_ff, state_in;
   action_type    action_ff, action_in;
   key_type       key_ff, key_in;
   cnt_type       count_ff, count_in;
   logic          signed_ff, signed_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    status_ff, status_in;
   idx_type       pos_ff, pos_in;
   cnt_type       cnt_out_ff, cnt_out_in;

   logic          accept;
   logic          go;
   logic          full;
   logic          hit;
   logic          do_insert;
   logic          do_delete;
   idx_type       slot;
   status_type    status_next;
   idx_type       pos_next;
   cnt_type       count_next;
   cell_ctrl_type ctrl;

   key_type       key_vec  [DEPTH];
   cell_flag_type flag_vec [DEPTH];
   logic [DEPTH-1:0] lt_vec;
   logic [DEPTH-1:0] eq_vec;
   logic [DEPTH-1:0] prefix_vec;
   logic [DEPTH-1:0] bound_vec;

   // chain of key cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prefix_vec[i] = 1'b1;
      end else begin : g_rest
         assign prefix_vec[i] = &lt_vec[i-1:0];
      end

      skt_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (IDX_BITS'(i)),
         .left_key   (key_vec[(i == 0) ? 0 : i - 1]),
         .right_key  (key_vec[(i == DEPTH - 1) ? i : i + 1]),
         .prefix_lt  (prefix_vec[i]),
         .key_out    (key_vec[i]),
         .flag_out   (flag_vec[i])
      );

      assign lt_vec[i] = flag_vec[i].lt;
      assign eq_vec[i] = flag_vec[i].eq;
   end

   // handshake qualifiers
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign go        = (state_ff == S_COMMIT) && !(rsp_valid_ff && rsp_stall);

   // slot resolution across the chain
   assign bound_vec = prefix_vec & ~lt_vec;
   assign hit       = |(bound_vec & eq_vec);
   assign full      = (count_ff == cnt_type'(DEPTH));

   always_comb begin
      slot = '0;
      for (int i = 0; i < DEPTH; i++) begin
         slot = slot | (bound_vec[i] ? IDX_BITS'(i) : '0);
      end
   end

   // request decode
   always_comb begin
      status_next = ST_OK;
      pos_next    = '0;
      count_next  = count_ff;
      do_insert   = 1'b0;
      do_delete   = 1'b0;
      unique case (action_ff)
         ACT_INSERT: begin
            if (full) begin
               status_next = ST_FULL;
            end else if (hit) begin
               status_next = ST_DUP;
            end else begin
               pos_next   = slot;
               count_next = count_ff + cnt_type'(1);
               do_insert  = go;
            end
         end
         ACT_SEARCH: begin
            if (hit) begin
               pos_next = slot;
            end else begin
               status_next = ST_MISSING;
            end
         end
         ACT_DELETE: begin
            if (hit) begin
               pos_next   = slot;
               count_next = count_ff - cnt_type'(1);
               do_delete  = go;
            end else begin
               status_next = ST_MISSING;
            end
         end
         ACT_NONE: begin
            status_next = ST_OK;
         end
         default: begin
            status_next = ST_OK;
         end
      endcase
   end

   // cell control broadcast
   always_comb begin
      ctrl.capture        = accept;
      ctrl.shift_up       = do_insert;
      ctrl.shift_down     = do_delete;
      ctrl.compare_signed = signed_ff;
      ctrl.probe_key      = req_key[KEY_BITS-1:0];
      ctrl.new_key        = key_ff;
      ctrl.count          = count_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // register updates
   always_comb begin
      action_in    = accept ? action_type'(req_action) : action_ff;
      key_in       = accept ? req_key[KEY_BITS-1:0] : key_ff;
      count_in     = go ? count_next : count_ff;
      signed_in    = csr_wr_en ? csr_wr_data : signed_ff;
      rsp_valid_in = go | (rsp_valid_ff & rsp_stall);
      status_in    = go ? status_next : status_ff;
      pos_in       = go ? pos_next : pos_ff;
      cnt_out_in   = go ? count_next : cnt_out_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         signed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         signed_ff    <= signed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      key_ff     <= key_in;
      status_ff  <= status_in;
      pos_ff     <= pos_in;
      cnt_out_ff <= cnt_out_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_position    = POS_FIELD_BITS'(pos_ff);
   assign rsp_entry_count = COUNT_FIELD_BITS'(cnt_out_ff);

   // checks, compare flags are only meaningful in the commit cycle
   `SKT_ASSERT_HOLD(a_bound_onehot0, clock, reset, (state_ff != S_COMMIT) || $onehot0(bound_vec))
   `SKT_ASSERT_HOLD(a_count_range, clock, reset, count_ff <= cnt_type'(DEPTH))
   `SKT_ASSERT_HOLD(a_slot_exists, clock, reset, (state_ff != S_COMMIT) || full || $onehot(bound_vec))
   `SKT_ASSERT_NEXT(a_insert_count, clock, reset, do_insert, count_ff == $past(count_ff) + cnt_type'(1))
   `SKT_ASSERT_NEXT(a_delete_count, clock, reset, do_delete, count_ff == $past(count_ff) - cnt_type'(1))

endmodule
